// ===== rtl/cigar_rcs_pkg.sv =====
// shared types, codes and constants for the cigar run coalescer
// no dependencies; imported by every module of the block
`default_nettype none

package cigar_rcs_pkg;

   // port widths fixed by the transaction format
   localparam int LEN_W               = 32;
   localparam int MODE_W              = 2;
   localparam int FRAC_BITS           = 16;
   localparam int MUT_W               = FRAC_BITS + 1;
   localparam int LENGTH_BITS_DEFAULT = 32;
   localparam int QUEUE_DEPTH         = 4;

   // one in unsigned q1.16
   localparam logic [MUT_W-1:0] Q16_ONE = MUT_W'(1) << FRAC_BITS;

   // request codes
   localparam logic REQ_APPEND = 1'b0;
   localparam logic REQ_FINISH = 1'b1;

   // result codes
   localparam logic KIND_RUN   = 1'b0;
   localparam logic KIND_STATS = 1'b1;

   // operation codes, the fourth code is not an operation
   localparam logic [MODE_W-1:0] OP_MATCH = 2'd0;
   localparam logic [MODE_W-1:0] OP_INS   = 2'd1;
   localparam logic [MODE_W-1:0] OP_DEL   = 2'd2;

   // control part of one queued command
   typedef struct packed {
      logic                has_run;
      logic                has_stats;
      logic [MODE_W-1:0]   run_mode;
   } cmd_ctrl_type;

   localparam int CTRL_W = $bits(cmd_ctrl_type);

   // back end sequencer
   typedef enum logic [1:0] {
      BK_IDLE,
      BK_RUN_OUT,
      BK_STATS_OUT
   } bk_state_type;

endpackage

`default_nettype wire

// ===== rtl/cigar_rcs_frac_div.sv =====
// bit-serial fraction unit: floor(num * 2^16 / den) for num <= den
// depends on cigar_rcs_pkg
`default_nettype none

module cigar_rcs_frac_div
   import cigar_rcs_pkg::*;
#(
   parameter int LENGTH_BITS = LENGTH_BITS_DEFAULT
) (
   input  wire                      clock,
   input  wire                      reset,
   input  wire                      start,
   input  wire  [LENGTH_BITS-1:0]   num,
   input  wire  [LENGTH_BITS-1:0]   den,
   output logic                     busy,
   output logic [MUT_W-1:0]         quot
);

   localparam int STEPS  = FRAC_BITS + 1;
   localparam int STEP_W = $clog2(STEPS);

   logic                    busy_ff, busy_in;
   logic [STEP_W-1:0]       step_ff, step_in;
   logic [LENGTH_BITS-1:0]  rem_ff, rem_in;
   logic [LENGTH_BITS-1:0]  den_ff, den_in;
   logic [MUT_W-1:0]        quot_ff, quot_in;

   logic [LENGTH_BITS:0]    shifted;
   logic [LENGTH_BITS:0]    diff;
   logic                    take_bit;

   // one restoring step per cycle, the first step has no shift
   always_comb begin
      shifted  = (step_ff == '0) ? {1'b0, rem_ff} : {rem_ff, 1'b0};
      take_bit = (shifted >= {1'b0, den_ff});
      diff     = shifted - {1'b0, den_ff};
   end

   // next state
   always_comb begin
      busy_in = busy_ff;
      step_in = step_ff;
      rem_in  = rem_ff;
      den_in  = den_ff;
      quot_in = quot_ff;
      if (start) begin
         busy_in = 1'b1;
         step_in = '0;
         rem_in  = num;
         den_in  = den;
         quot_in = '0;
      end else if (busy_ff) begin
         rem_in  = take_bit ? diff[LENGTH_BITS-1:0] : shifted[LENGTH_BITS-1:0];
         quot_in = {quot_ff[MUT_W-2:0], take_bit};
         step_in = step_ff + STEP_W'(1);
         if (step_ff == STEP_W'(STEPS - 1)) begin
            busy_in = 1'b0;
         end
      end
   end

   // control registers
   always_ff @(posedge clock) begin
      if (reset) begin
         busy_ff <= 1'b0;
         step_ff <= '0;
      end else begin
         busy_ff <= busy_in;
         step_ff <= step_in;
      end
   end

   // datapath registers
   always_ff @(posedge clock) begin
      rem_ff  <= rem_in;
      den_ff  <= den_in;
      quot_ff <= quot_in;
   end

   assign busy = busy_ff;
   assign quot = (quot_ff > Q16_ONE) ? Q16_ONE : quot_ff;

endmodule

`default_nettype wire

// ===== rtl/cigar_rcs_queue.sv =====
// short command queue between the front and back ends
// depends on cigar_rcs_pkg
`default_nettype none

module cigar_rcs_queue
   import cigar_rcs_pkg::*;
#(
   parameter int WIDTH = CTRL_W
) (
   input  wire               clock,
   input  wire               reset,
   input  wire               push,
   input  wire  [WIDTH-1:0]  push_data,
   input  wire               pop,
   output logic [WIDTH-1:0]  pop_data,
   output logic              full,
   output logic              empty
);

   localparam int PTR_W = $clog2(QUEUE_DEPTH);
   localparam int CNT_W = $clog2(QUEUE_DEPTH + 1);

   logic [WIDTH-1:0] entry_ff [QUEUE_DEPTH];
   logic [PTR_W-1:0] wr_ptr_ff, wr_ptr_in;
   logic [PTR_W-1:0] rd_ptr_ff, rd_ptr_in;
   logic [CNT_W-1:0] count_ff, count_in;

   logic do_push;
   logic do_pop;

   assign do_push = push && !full;
   assign do_pop  = pop && !empty;

   // pointer and fill count update
   always_comb begin
      wr_ptr_in = wr_ptr_ff;
      rd_ptr_in = rd_ptr_ff;
      count_in  = count_ff;
      if (do_push) begin
         wr_ptr_in = (wr_ptr_ff == PTR_W'(QUEUE_DEPTH - 1)) ? '0 : wr_ptr_ff + PTR_W'(1);
      end
      if (do_pop) begin
         rd_ptr_in = (rd_ptr_ff == PTR_W'(QUEUE_DEPTH - 1)) ? '0 : rd_ptr_ff + PTR_W'(1);
      end
      if (do_push && !do_pop) begin
         count_in = count_ff + CNT_W'(1);
      end else if (do_pop && !do_push) begin
         count_in = count_ff - CNT_W'(1);
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff <= '0;
         rd_ptr_ff <= '0;
         count_ff  <= '0;
      end else begin
         wr_ptr_ff <= wr_ptr_in;
         rd_ptr_ff <= rd_ptr_in;
         count_ff  <= count_in;
      end
   end

   // entry storage
   always_ff @(posedge clock) begin
      if (do_push) begin
         entry_ff[wr_ptr_ff] <= push_data;
      end
   end

   assign pop_data = entry_ff[rd_ptr_ff];
   assign full     = (count_ff == CNT_W'(QUEUE_DEPTH));
   assign empty    = (count_ff == '0);

   // fill count stays within the depth
   assert property (@(posedge clock) disable iff (reset)
      count_ff <= CNT_W'(QUEUE_DEPTH))
      else $error("queue fill count beyond depth");

endmodule

`default_nettype wire

// ===== rtl/cigar_rcs_front.sv =====
// front end: accepts transactions, merges runs, keeps saturating totals
// depends on cigar_rcs_pkg; feeds cigar_rcs_queue
`default_nettype none

module cigar_rcs_front
   import cigar_rcs_pkg::*;
#(
   parameter int LENGTH_BITS = LENGTH_BITS_DEFAULT
) (
   input  wire                      clock,
   input  wire                      reset,
   input  wire                      push,
   output logic                     full,
   input  wire                      req_type,
   input  wire  [LEN_W-1:0]         req_run_length,
   input  wire  [MODE_W-1:0]        req_op_mode,
   input  wire                      q_full,
   output logic                     q_push,
   output cmd_ctrl_type             q_ctrl,
   output logic [LENGTH_BITS-1:0]   q_run_len,
   output logic [LENGTH_BITS-1:0]   q_query,
   output logic [LENGTH_BITS-1:0]   q_target,
   output logic [LENGTH_BITS-1:0]   q_match
);

   localparam int WIDE = (LENGTH_BITS > LEN_W) ? LENGTH_BITS : LEN_W;
   localparam logic [WIDE-1:0] LEN_MAX_WIDE = WIDE'({LENGTH_BITS{1'b1}});

   logic [LENGTH_BITS-1:0] pend_len_ff, pend_len_in;
   logic [MODE_W-1:0]      pend_mode_ff, pend_mode_in;
   logic                   pend_valid_ff, pend_valid_in;
   logic [LENGTH_BITS-1:0] query_ff, query_in;
   logic [LENGTH_BITS-1:0] target_ff, target_in;
   logic [LENGTH_BITS-1:0] match_ff, match_in;

   logic [WIDE-1:0]        len_wide;
   logic [LENGTH_BITS-1:0] len_clamp;
   logic                   accept;
   logic                   mode_ok;
   logic                   run_ok;
   logic                   same_mode;

   function automatic logic [LENGTH_BITS-1:0] sat_add(
      input logic [LENGTH_BITS-1:0] a,
      input logic [LENGTH_BITS-1:0] b
   );
      logic [LENGTH_BITS:0] s;
      s = {1'b0, a} + {1'b0, b};
      return s[LENGTH_BITS] ? '1 : s[LENGTH_BITS-1:0];
   endfunction

   // clamp the incoming length to the internal maximum
   always_comb begin
      len_wide  = WIDE'(req_run_length);
      len_clamp = (len_wide > LEN_MAX_WIDE) ? '1 : len_wide[LENGTH_BITS-1:0];
   end

   // classify the transaction
   assign accept    = push && !q_full;
   assign mode_ok   = (req_op_mode == OP_MATCH) || (req_op_mode == OP_INS) ||
                      (req_op_mode == OP_DEL);
   assign run_ok    = (req_run_length != '0) && mode_ok;
   assign same_mode = pend_valid_ff && (pend_mode_ff == req_op_mode);

   // merge, count and build the command
   always_comb begin
      pend_len_in   = pend_len_ff;
      pend_mode_in  = pend_mode_ff;
      pend_valid_in = pend_valid_ff;
      query_in      = query_ff;
      target_in     = target_ff;
      match_in      = match_ff;
      q_push        = 1'b0;
      q_ctrl        = '{has_run: pend_valid_ff, has_stats: 1'b0, run_mode: pend_mode_ff};
      if (accept) begin
         if (req_type == REQ_APPEND) begin
            if (run_ok) begin
               if (req_op_mode != OP_DEL) begin
                  query_in = sat_add(query_ff, len_clamp);
               end
               if (req_op_mode != OP_INS) begin
                  target_in = sat_add(target_ff, len_clamp);
               end
               if (req_op_mode == OP_MATCH) begin
                  match_in = sat_add(match_ff, len_clamp);
               end
               if (same_mode) begin
                  pend_len_in = sat_add(pend_len_ff, len_clamp);
               end else begin
                  q_push        = pend_valid_ff;
                  pend_len_in   = len_clamp;
                  pend_mode_in  = req_op_mode;
                  pend_valid_in = 1'b1;
               end
            end
         end else begin
            q_push           = 1'b1;
            q_ctrl.has_stats = 1'b1;
            pend_len_in      = '0;
            pend_mode_in     = OP_MATCH;
            pend_valid_in    = 1'b0;
            query_in         = '0;
            target_in        = '0;
            match_in         = '0;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         pend_len_ff   <= '0;
         pend_mode_ff  <= OP_MATCH;
         pend_valid_ff <= 1'b0;
         query_ff      <= '0;
         target_ff     <= '0;
         match_ff      <= '0;
      end else begin
         pend_len_ff   <= pend_len_in;
         pend_mode_ff  <= pend_mode_in;
         pend_valid_ff <= pend_valid_in;
         query_ff      <= query_in;
         target_ff     <= target_in;
         match_ff      <= match_in;
      end
   end

   assign full      = q_full;
   assign q_run_len = pend_len_ff;
   assign q_query   = query_ff;
   assign q_target  = target_ff;
   assign q_match   = match_ff;

   // match total never exceeds either sequence total
   assert property (@(posedge clock) disable iff (reset)
      (match_ff <= query_ff) && (match_ff <= target_ff))
      else $error("match total above query or target total");

   // a pending run is never empty
   assert property (@(posedge clock) disable iff (reset)
      pend_valid_ff |-> (pend_len_ff != '0))
      else $error("pending run of zero length");

endmodule

`default_nettype wire

// ===== rtl/cigar_rcs_back.sv =====
// back end: emits run results and computes the statistics report
// depends on cigar_rcs_pkg and cigar_rcs_frac_div
`default_nettype none

module cigar_rcs_back
   import cigar_rcs_pkg::*;
#(
   parameter int LENGTH_BITS = LENGTH_BITS_DEFAULT
) (
   input  wire                      clock,
   input  wire                      reset,
   input  wire                      q_empty,
   output logic                     q_pop,
   input  cmd_ctrl_type             q_ctrl,
   input  wire  [LENGTH_BITS-1:0]   q_run_len,
   input  wire  [LENGTH_BITS-1:0]   q_query,
   input  wire  [LENGTH_BITS-1:0]   q_target,
   input  wire  [LENGTH_BITS-1:0]   q_match,
   output logic                     empty,
   input  wire                      pop,
   output logic                     rsp_item_kind,
   output logic [LEN_W-1:0]         rsp_out_run_length,
   output logic [MODE_W-1:0]        rsp_out_run_mode,
   output logic [LEN_W-1:0]         rsp_query_total,
   output logic [LEN_W-1:0]         rsp_target_total,
   output logic [LEN_W-1:0]         rsp_match_total,
   output logic [MUT_W-1:0]         rsp_mutability_q16,
   output logic                     rsp_zero_length_fault,
   output logic                     rsp_last_of_run
);

   localparam int WIDE = (LENGTH_BITS > LEN_W) ? LENGTH_BITS : LEN_W;

   bk_state_type           state_ff, state_in;
   cmd_ctrl_type           work_ctrl_ff, work_ctrl_in;
   logic [LENGTH_BITS-1:0] work_len_ff, work_len_in;
   logic [LENGTH_BITS-1:0] work_query_ff, work_query_in;
   logic [LENGTH_BITS-1:0] work_target_ff, work_target_in;
   logic [LENGTH_BITS-1:0] work_match_ff, work_match_in;

   logic                   out_valid_ff, out_valid_in;
   logic                   out_kind_ff, out_kind_in;
   logic [LEN_W-1:0]       out_len_ff, out_len_in;
   logic [MODE_W-1:0]      out_mode_ff, out_mode_in;
   logic [LEN_W-1:0]       out_query_ff, out_query_in;
   logic [LEN_W-1:0]       out_target_ff, out_target_in;
   logic [LEN_W-1:0]       out_match_ff, out_match_in;
   logic [MUT_W-1:0]       out_mut_ff, out_mut_in;
   logic                   out_fault_ff, out_fault_in;
   logic                   out_last_ff, out_last_in;

   logic                   slot_free;
   logic                   take;
   logic                   div_start;
   logic                   load_run;
   logic                   load_stats;
   logic                   busy_t, busy_q;
   logic                   div_busy;
   logic [MUT_W-1:0]       quot_t, quot_q;
   logic [MUT_W:0]         quot_sum;
   logic                   fault;
   logic [MUT_W-1:0]       mut;

   function automatic logic [LEN_W-1:0] to_port(input logic [LENGTH_BITS-1:0] v);
      logic [WIDE-1:0] w;
      w = WIDE'(v);
      return w[LEN_W-1:0];
   endfunction

   // m / target and m / query, started straight from the queue head
   cigar_rcs_frac_div #(
      .LENGTH_BITS (LENGTH_BITS)
   ) u_div_target (
      .clock (clock),
      .reset (reset),
      .start (div_start),
      .num   (q_match),
      .den   (q_target),
      .busy  (busy_t),
      .quot  (quot_t)
   );

   cigar_rcs_frac_div #(
      .LENGTH_BITS (LENGTH_BITS)
   ) u_div_query (
      .clock (clock),
      .reset (reset),
      .start (div_start),
      .num   (q_match),
      .den   (q_query),
      .busy  (busy_q),
      .quot  (quot_q)
   );

   assign div_busy  = busy_t || busy_q;
   assign slot_free = !out_valid_ff || pop;

   // mutability from the two fractions
   always_comb begin
      quot_sum = {1'b0, quot_t} + {1'b0, quot_q};
      fault    = (work_query_ff == '0) || (work_target_ff == '0);
      mut      = fault ? '0 : Q16_ONE - quot_sum[MUT_W:1];
   end

   // next state
   always_comb begin
      state_in = state_ff;
      unique case (state_ff)
         BK_IDLE: begin
            if (!q_empty) begin
               state_in = q_ctrl.has_run ? BK_RUN_OUT : BK_STATS_OUT;
            end
         end
         BK_RUN_OUT: begin
            if (slot_free) begin
               state_in = work_ctrl_ff.has_stats ? BK_STATS_OUT : BK_IDLE;
            end
         end
         BK_STATS_OUT: begin
            if (slot_free && !div_busy) begin
               state_in = BK_IDLE;
            end
         end
         default: begin
            state_in = BK_IDLE;
         end
      endcase
   end

   // sequencer outputs
   always_comb begin
      take       = 1'b0;
      load_run   = 1'b0;
      load_stats = 1'b0;
      unique case (state_ff)
         BK_IDLE:      take       = !q_empty;
         BK_RUN_OUT:   load_run   = slot_free;
         BK_STATS_OUT: load_stats = slot_free && !div_busy;
         default:      take       = 1'b0;
      endcase
      div_start = take && q_ctrl.has_stats;
      q_pop     = take;
   end

   // working copy of the command
   always_comb begin
      work_ctrl_in   = work_ctrl_ff;
      work_len_in    = work_len_ff;
      work_query_in  = work_query_ff;
      work_target_in = work_target_ff;
      work_match_in  = work_match_ff;
      if (take) begin
         work_ctrl_in   = q_ctrl;
         work_len_in    = q_run_len;
         work_query_in  = q_query;
         work_target_in = q_target;
         work_match_in  = q_match;
      end
   end

   // result register
   always_comb begin
      out_valid_in  = out_valid_ff && !pop;
      out_kind_in   = out_kind_ff;
      out_len_in    = out_len_ff;
      out_mode_in   = out_mode_ff;
      out_query_in  = out_query_ff;
      out_target_in = out_target_ff;
      out_match_in  = out_match_ff;
      out_mut_in    = out_mut_ff;
      out_fault_in  = out_fault_ff;
      out_last_in   = out_last_ff;
      if (load_run) begin
         out_valid_in  = 1'b1;
         out_kind_in   = KIND_RUN;
         out_len_in    = to_port(work_len_ff);
         out_mode_in   = work_ctrl_ff.run_mode;
         out_query_in  = '0;
         out_target_in = '0;
         out_match_in  = '0;
         out_mut_in    = '0;
         out_fault_in  = 1'b0;
         out_last_in   = !work_ctrl_ff.has_stats;
      end else if (load_stats) begin
         out_valid_in  = 1'b1;
         out_kind_in   = KIND_STATS;
         out_len_in    = '0;
         out_mode_in   = OP_MATCH;
         out_query_in  = to_port(work_query_ff);
         out_target_in = to_port(work_target_ff);
         out_match_in  = to_port(work_match_ff);
         out_mut_in    = mut;
         out_fault_in  = fault;
         out_last_in   = 1'b1;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= BK_IDLE;
         work_ctrl_ff <= '0;
         out_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         work_ctrl_ff <= work_ctrl_in;
         out_valid_ff <= out_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      work_len_ff    <= work_len_in;
      work_query_ff  <= work_query_in;
      work_target_ff <= work_target_in;
      work_match_ff  <= work_match_in;
      out_kind_ff    <= out_kind_in;
      out_len_ff     <= out_len_in;
      out_mode_ff    <= out_mode_in;
      out_query_ff   <= out_query_in;
      out_target_ff  <= out_target_in;
      out_match_ff   <= out_match_in;
      out_mut_ff     <= out_mut_in;
      out_fault_ff   <= out_fault_in;
      out_last_ff    <= out_last_in;
   end

   assign empty                 = !out_valid_ff;
   assign rsp_item_kind         = out_kind_ff;
   assign rsp_out_run_length    = out_len_ff;
   assign rsp_out_run_mode      = out_mode_ff;
   assign rsp_query_total       = out_query_ff;
   assign rsp_target_total      = out_target_ff;
   assign rsp_match_total       = out_match_ff;
   assign rsp_mutability_q16    = out_mut_ff;
   assign rsp_zero_length_fault = out_fault_ff;
   assign rsp_last_of_run       = out_last_ff;

   // waiting on the report only for a command that asked for one
   assert property (@(posedge clock) disable iff (reset)
      (state_ff == BK_STATS_OUT) |-> work_ctrl_ff.has_stats)
      else $error("report state without a report command");

   // a new division never starts over a running one
   assert property (@(posedge clock) disable iff (reset)
      div_start |-> !div_busy)
      else $error("division started while busy");

endmodule

`default_nettype wire

// ===== rtl/cigar_run_coalescer_with_stats_unit.sv =====
// Run coalescer with alignment statistics. The front end takes one transaction
// per cycle while its four-entry command queue has room: appends merge and count
// in that cycle. For each completed run it emits, the back end takes the command
// when idle and loads the run once the output register is free. For a finish, the
// back end takes the command, then two bit-serial fraction units (one quotient bit
// per cycle) work out m/T and m/Q in parallel, and then it loads the report. A run
// flushed by the finish goes out before the report; the units keep working meanwhile.
// One output register holds the oldest result; the next transaction is accepted
// while it waits.
// depends on cigar_rcs_pkg, cigar_rcs_front, cigar_rcs_queue, cigar_rcs_back
`default_nettype none

module cigar_run_coalescer_with_stats_unit
   import cigar_rcs_pkg::*;
#(
   parameter int LENGTH_BITS = LENGTH_BITS_DEFAULT
) (
   input  wire                 clock,
   input  wire                 reset,
   input  wire                 push,
   output logic                full,
   input  wire                 req_type,
   input  wire  [LEN_W-1:0]    req_run_length,
   input  wire  [MODE_W-1:0]   req_op_mode,
   output logic                empty,
   input  wire                 pop,
   output logic                rsp_item_kind,
   output logic [LEN_W-1:0]    rsp_out_run_length,
   output logic [MODE_W-1:0]   rsp_out_run_mode,
   output logic [LEN_W-1:0]    rsp_query_total,
   output logic [LEN_W-1:0]    rsp_target_total,
   output logic [LEN_W-1:0]    rsp_match_total,
   output logic [MUT_W-1:0]    rsp_mutability_q16,
   output logic                rsp_zero_length_fault,
   output logic                rsp_last_of_run
);

   localparam int Q_W = CTRL_W + 4 * LENGTH_BITS;

   logic                   q_full;
   logic                   q_empty;
   logic                   q_push;
   logic                   q_pop;
   cmd_ctrl_type           f_ctrl;
   logic [LENGTH_BITS-1:0] f_run_len, f_query, f_target, f_match;
   cmd_ctrl_type           b_ctrl;
   logic [LENGTH_BITS-1:0] b_run_len, b_query, b_target, b_match;
   logic [Q_W-1:0]         q_wr_data;
   logic [Q_W-1:0]         q_rd_data;

   // front end
   cigar_rcs_front #(
      .LENGTH_BITS (LENGTH_BITS)
   ) u_front (
      .clock          (clock),
      .reset          (reset),
      .push           (push),
      .full           (full),
      .req_type       (req_type),
      .req_run_length (req_run_length),
      .req_op_mode    (req_op_mode),
      .q_full         (q_full),
      .q_push         (q_push),
      .q_ctrl         (f_ctrl),
      .q_run_len      (f_run_len),
      .q_query        (f_query),
      .q_target       (f_target),
      .q_match        (f_match)
   );

   // command queue
   assign q_wr_data = {f_ctrl, f_run_len, f_query, f_target, f_match};

   cigar_rcs_queue #(
      .WIDTH (Q_W)
   ) u_queue (
      .clock     (clock),
      .reset     (reset),
      .push      (q_push),
      .push_data (q_wr_data),
      .pop       (q_pop),
      .pop_data  (q_rd_data),
      .full      (q_full),
      .empty     (q_empty)
   );

   assign {b_ctrl, b_run_len, b_query, b_target, b_match} = q_rd_data;

   // back end
   cigar_rcs_back #(
      .LENGTH_BITS (LENGTH_BITS)
   ) u_back (
      .clock                 (clock),
      .reset                 (reset),
      .q_empty               (q_empty),
      .q_pop                 (q_pop),
      .q_ctrl                (b_ctrl),
      .q_run_len             (b_run_len),
      .q_query               (b_query),
      .q_target              (b_target),
      .q_match               (b_match),
      .empty                 (empty),
      .pop                   (pop),
      .rsp_item_kind         (rsp_item_kind),
      .rsp_out_run_length    (rsp_out_run_length),
      .rsp_out_run_mode      (rsp_out_run_mode),
      .rsp_query_total       (rsp_query_total),
      .rsp_target_total      (rsp_target_total),
      .rsp_match_total       (rsp_match_total),
      .rsp_mutability_q16    (rsp_mutability_q16),
      .rsp_zero_length_fault (rsp_zero_length_fault),
      .rsp_last_of_run       (rsp_last_of_run)
   );

endmodule

`default_nettype wire
